// ----- hw/rtl/cmpu_pkg.sv -----
// Shared package for the composition unranking block.
// Holds field widths, defaults, state and emit codes and the controller/datapath structs.
// Used by cmpu_ctrl, cmpu_datapath and composition_unrank.
package cmpu_pkg;

  localparam int DEF_MAX_PARTS = 8;
  localparam int DEF_MAX_UNITS = 255;

  localparam int RANK_W      = 44;
  localparam int UNITS_W     = 8;
  localparam int PART_NUM_W  = 4;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 8;

  localparam logic [PART_NUM_W-1:0] PART_NUM_RESET = 4'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_RANGE,
    ST_STEP,
    ST_LAST
  } state_t;

  typedef enum logic [1:0] {
    EMIT_PART,
    EMIT_LAST,
    EMIT_RANGE
  } emit_kind_t;

  typedef struct packed {
    logic       load;
    logic       init_step;
    logic       descend;
    logic       next_part;
    logic       emit;
    emit_kind_t emit_kind;
  } cmpu_cmd_t;

  typedef struct packed {
    logic init_done;
    logic ge;
    logic l_zero;
    logic k_zero;
    logic out_free;
  } cmpu_status_t;

endpackage

// ----- hw/rtl/cmpu_ctrl.sv -----
// Controller state machine of the composition unranking block.
// Sequences table build, range check, per-part stepping and result emission.
// Depends on cmpu_pkg for state, command and status types.
module cmpu_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  cmpu_pkg::cmpu_status_t status,
  output cmpu_pkg::cmpu_cmd_t    cmd
);

  cmpu_pkg::state_t state_r;
  cmpu_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cmpu_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    cmd           = '0;
    cmd.emit_kind = cmpu_pkg::EMIT_PART;
    unique case (state_r)
      cmpu_pkg::ST_IDLE: begin
        // No word is taken while reset is held.
        in_tready = rst_n;
        if (in_tvalid && rst_n) begin
          cmd.load  = 1'b1;
          state_nxt = cmpu_pkg::ST_INIT;
        end
      end
      cmpu_pkg::ST_INIT: begin
        if (status.init_done) begin
          state_nxt = cmpu_pkg::ST_RANGE;
        end else begin
          cmd.init_step = 1'b1;
        end
      end
      cmpu_pkg::ST_RANGE: begin
        if (status.ge) begin
          if (status.out_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = cmpu_pkg::EMIT_RANGE;
            state_nxt     = cmpu_pkg::ST_IDLE;
          end
        end else if (status.k_zero) begin
          state_nxt = cmpu_pkg::ST_LAST;
        end else begin
          cmd.next_part = 1'b1;
          state_nxt     = cmpu_pkg::ST_STEP;
        end
      end
      cmpu_pkg::ST_STEP: begin
        if (status.l_zero || !status.ge) begin
          if (status.out_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = cmpu_pkg::EMIT_PART;
            cmd.next_part = 1'b1;
            if (status.k_zero) begin
              state_nxt = cmpu_pkg::ST_LAST;
            end
          end
        end else begin
          cmd.descend = 1'b1;
        end
      end
      cmpu_pkg::ST_LAST: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = cmpu_pkg::EMIT_LAST;
          state_nxt     = cmpu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cmpu_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/cmpu_datapath.sv -----
// Datapath of the composition unranking block: binomial column registers, rank,
// remaining units, part counter and the output register.
// Depends on cmpu_pkg; driven by cmpu_ctrl through command and status structs.
module cmpu_datapath #(
  parameter int MAX_PARTS = cmpu_pkg::DEF_MAX_PARTS,
  parameter int MAX_UNITS = cmpu_pkg::DEF_MAX_UNITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [cmpu_pkg::RANK_W-1:0]       rank_index,
  input  logic [cmpu_pkg::UNITS_W-1:0]      total_units,
  input  logic [cmpu_pkg::PART_NUM_W-1:0]   part_number,
  input  cmpu_pkg::cmpu_cmd_t               cmd,
  output cmpu_pkg::cmpu_status_t            status,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [cmpu_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tlast,
  output logic                              out_tuser
);

  localparam int UMAX    = (MAX_UNITS < 255) ? MAX_UNITS : 255;
  localparam int NB      = $clog2(UMAX + MAX_PARTS);
  localparam int BOUND_W = (MAX_PARTS - 1) * NB + 1;
  localparam int CNT_W   = (BOUND_W > cmpu_pkg::RANK_W + 1) ? BOUND_W : cmpu_pkg::RANK_W + 1;
  localparam int KW      = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int CW      = $clog2(256 + MAX_PARTS);
  localparam int UW      = cmpu_pkg::UNITS_W;

  // Column t holds C(L + t, t) for the current remaining units L.
  logic [CNT_W-1:0]              vec_r   [MAX_PARTS];
  logic [CNT_W-1:0]              vec_nxt [MAX_PARTS];
  logic [cmpu_pkg::RANK_W-1:0]   rank_r, rank_nxt;
  logic [UW-1:0]                 l_r, l_nxt;
  logic [UW-1:0]                 j_r, j_nxt;
  logic [KW-1:0]                 k_r, k_nxt;
  logic [KW-1:0]                 kmax_r, kmax_nxt;
  logic [CW-1:0]                 c_r, c_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [cmpu_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                          out_last_r, out_last_nxt;
  logic                          out_range_r, out_range_nxt;

  logic [CNT_W-1:0]              cnt_sel;
  logic [CNT_W-1:0]              rank_ext;
  logic [KW-1:0]                 k_load;
  logic [UW-1:0]                 l_load;
  logic                          out_free;

  assign cnt_sel  = vec_r[k_r];
  assign rank_ext = CNT_W'(rank_r);
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    if (part_number == '0) begin
      k_load = '0;
    end else if (int'(part_number) > MAX_PARTS) begin
      k_load = KW'(MAX_PARTS - 1);
    end else begin
      k_load = KW'(part_number - 4'd1);
    end
    if (int'(total_units) > UMAX) begin
      l_load = UW'(UMAX);
    end else begin
      l_load = total_units;
    end
  end

  always_comb begin
    status.init_done = (c_r == (CW'(l_r) + CW'(kmax_r)));
    status.ge        = (rank_ext >= cnt_sel);
    status.l_zero    = (l_r == '0);
    status.k_zero    = (k_r == '0);
    status.out_free  = out_free;
  end

  always_comb begin
    vec_nxt  = vec_r;
    rank_nxt = rank_r;
    l_nxt    = l_r;
    j_nxt    = j_r;
    k_nxt    = k_r;
    kmax_nxt = kmax_r;
    c_nxt    = c_r;
    if (cmd.load) begin
      for (int t = 0; t < MAX_PARTS; t++) begin
        vec_nxt[t] = CNT_W'(1);
      end
      rank_nxt = rank_index;
      l_nxt    = l_load;
      j_nxt    = '0;
      k_nxt    = k_load;
      kmax_nxt = k_load;
      c_nxt    = '0;
    end else if (cmd.init_step) begin
      // Skewed wavefront: column t adds column t - 1 while the step counter minus t lies below L,
      // so column t - 1 already holds its value for that step.
      for (int t = 1; t < MAX_PARTS; t++) begin
        if ((c_r >= CW'(t)) && ((c_r - CW'(t)) < CW'(l_r))) begin
          vec_nxt[t] = vec_r[t] + vec_r[t-1];
        end
      end
      c_nxt = c_r + CW'(1);
    end else if (cmd.descend) begin
      // C(L - 1 + t, t) = C(L + t, t) - C(L + t - 1, t - 1), all columns at once.
      for (int t = 1; t < MAX_PARTS; t++) begin
        vec_nxt[t] = vec_r[t] - vec_r[t-1];
      end
      rank_nxt = cmpu_pkg::RANK_W'(rank_ext - cnt_sel);
      l_nxt    = l_r - UW'(1);
      j_nxt    = j_r + UW'(1);
    end else if (cmd.next_part) begin
      j_nxt = '0;
      if (k_r != '0) begin
        k_nxt = k_r - KW'(1);
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_range_nxt = out_range_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      unique case (cmd.emit_kind)
        cmpu_pkg::EMIT_PART: begin
          out_data_nxt  = j_r;
          out_last_nxt  = 1'b0;
          out_range_nxt = 1'b0;
        end
        cmpu_pkg::EMIT_LAST: begin
          out_data_nxt  = l_r;
          out_last_nxt  = 1'b1;
          out_range_nxt = 1'b0;
        end
        cmpu_pkg::EMIT_RANGE: begin
          out_data_nxt  = '0;
          out_last_nxt  = 1'b1;
          out_range_nxt = 1'b1;
        end
        default: begin
          out_data_nxt  = '0;
          out_last_nxt  = 1'b1;
          out_range_nxt = 1'b1;
        end
      endcase
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vec_r       <= vec_nxt;
    rank_r      <= rank_nxt;
    l_r         <= l_nxt;
    j_r         <= j_nxt;
    k_r         <= k_nxt;
    kmax_r      <= kmax_nxt;
    c_r         <= c_nxt;
    out_data_r  <= out_data_nxt;
    out_last_r  <= out_last_nxt;
    out_range_r <= out_range_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_range_r;

endmodule

// ----- hw/rtl/composition_unrank.sv -----
// After a word is accepted the block builds the binomial table and runs the range check;
// an out-of-range word yields a flagged result, else the block descends once per unit given
// to an early part and emits each part, holding while the output register is full.
// Throughput: one word at a time; the next is taken in the cycle after the final result
// enters the output register.
// Reset: part_number returns to 2, the controller goes idle and the output register empties.
module composition_unrank #(
  parameter int MAX_PARTS = cmpu_pkg::DEF_MAX_PARTS,
  parameter int MAX_UNITS = cmpu_pkg::DEF_MAX_UNITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [43:0] rank_index, [51:44] total_units, [55:52] zero
  input  logic [cmpu_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] part_count
  output logic [cmpu_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // last_part
  output logic                                out_tlast,
  // [0] out_of_range
  output logic                                out_tuser,
  input  logic                                cfg_wr_en,
  input  logic [cmpu_pkg::PART_NUM_W-1:0]     cfg_wr_data
);

  logic [cmpu_pkg::PART_NUM_W-1:0] part_number_r;
  logic [cmpu_pkg::PART_NUM_W-1:0] part_number_nxt;
  cmpu_pkg::cmpu_cmd_t             cmd;
  cmpu_pkg::cmpu_status_t          status;

  assign part_number_nxt = cfg_wr_en ? cfg_wr_data : part_number_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_number_r <= cmpu_pkg::PART_NUM_RESET;
    end else begin
      part_number_r <= part_number_nxt;
    end
  end

  cmpu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  cmpu_datapath #(
    .MAX_PARTS (MAX_PARTS),
    .MAX_UNITS (MAX_UNITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .rank_index  (in_tdata[cmpu_pkg::RANK_W-1:0]),
    .total_units (in_tdata[cmpu_pkg::RANK_W +: cmpu_pkg::UNITS_W]),
    .part_number (part_number_r),
    .cmd         (cmd),
    .status      (status),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

endmodule
